@@ rtl/mark_bitmap_range_scan_macros.svh @@
// assertion helpers for the block's datapath module
// each expects clk and rst_n in the module that uses it
`ifndef MARK_BITMAP_RANGE_SCAN_MACROS_SVH
`define MARK_BITMAP_RANGE_SCAN_MACROS_SVH

// same-cycle implication
`define MBRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MBRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mbrs_pkg.sv @@
`timescale 1ns / 1ps

package mbrs_pkg;

  // fixed field widths
  localparam int ADDR_W    = 48;
  localparam int IDX_W     = 39;
  localparam int DATA_W    = 64;
  localparam int CFG_IDX_W = 2;

  // defaults for the top-level parameters
  localparam int WORD_BITS_DEF   = 64;
  localparam int ALIGN_BYTES_DEF = 8;

  // four partial products per reciprocal multiplication
  localparam int DIV_STEPS = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END   = 2'd2;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DIV_A,
    ST_MID,
    ST_DIV_W,
    ST_IDLE,
    ST_BASE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic       load_div;
    logic       take_word;
    logic       div_step;
    logic       phase_bit;
    logic [1:0] mul_sel;
    logic       accept;
    logic       base_load;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic word_zero;
    logic last_bit;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/mbrs_in_if.sv @@
`timescale 1ns / 1ps

interface mbrs_in_if;
  logic                       valid;
  logic                       ready;
  logic [mbrs_pkg::IDX_W-1:0]  word_index;
  logic [mbrs_pkg::DATA_W-1:0] word_bits;

  modport source (output valid, output word_index, output word_bits, input ready);
  modport sink (input valid, input word_index, input word_bits, output ready);
endinterface

@@ rtl/mbrs_out_if.sv @@
`timescale 1ns / 1ps

interface mbrs_out_if;
  logic                       valid;
  logic                       ready;
  logic [mbrs_pkg::ADDR_W-1:0] object_address;
  logic                       last_of_word;

  modport source (output valid, output object_address, output last_of_word, input ready);
  modport sink (input valid, input object_address, input last_of_word, output ready);
endinterface

@@ rtl/mbrs_ctrl.sv @@
`timescale 1ns / 1ps

module mbrs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               in_valid,
  output logic               in_ready,
  input  mbrs_pkg::sts_t     sts,
  output mbrs_pkg::cmd_t     cmd
);

  localparam int CNT_W = $clog2(mbrs_pkg::DIV_STEPS);

  mbrs_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             cnt_last;

  assign cnt_last = (cnt_r == CNT_W'(mbrs_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mbrs_pkg::ST_LOAD;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = '0;
    case (state_r)
      mbrs_pkg::ST_LOAD: state_nxt = mbrs_pkg::ST_DIV_A;
      mbrs_pkg::ST_DIV_A: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_last) begin
          state_nxt = mbrs_pkg::ST_MID;
          cnt_nxt   = '0;
        end
      end
      mbrs_pkg::ST_MID: state_nxt = mbrs_pkg::ST_DIV_W;
      mbrs_pkg::ST_DIV_W: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_last) begin
          state_nxt = mbrs_pkg::ST_IDLE;
          cnt_nxt   = '0;
        end
      end
      mbrs_pkg::ST_IDLE: begin
        if (in_valid && in_ready) state_nxt = mbrs_pkg::ST_BASE;
      end
      mbrs_pkg::ST_BASE: state_nxt = mbrs_pkg::ST_SCAN;
      mbrs_pkg::ST_SCAN: begin
        if (sts.word_zero) state_nxt = mbrs_pkg::ST_IDLE;
        else if (sts.out_free && sts.last_bit) state_nxt = mbrs_pkg::ST_IDLE;
      end
      default: state_nxt = mbrs_pkg::ST_LOAD;
    endcase
    // new window settings restart the setup
    if (cfg_we) begin
      state_nxt = mbrs_pkg::ST_LOAD;
      cnt_nxt   = '0;
    end
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      mbrs_pkg::ST_LOAD:  cmd.load_div = 1'b1;
      mbrs_pkg::ST_DIV_A: begin
        cmd.div_step = 1'b1;
        cmd.mul_sel  = cnt_r;
      end
      mbrs_pkg::ST_MID:   cmd.take_word = 1'b1;
      mbrs_pkg::ST_DIV_W: begin
        cmd.div_step  = 1'b1;
        cmd.phase_bit = 1'b1;
        cmd.mul_sel   = cnt_r;
      end
      mbrs_pkg::ST_IDLE: begin
        in_ready   = !cfg_we;
        cmd.accept = in_valid && !cfg_we;
      end
      mbrs_pkg::ST_BASE: cmd.base_load = 1'b1;
      mbrs_pkg::ST_SCAN: cmd.emit = !sts.word_zero && sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/mbrs_dpath.sv @@
`timescale 1ns / 1ps
`include "mark_bitmap_range_scan_macros.svh"

module mbrs_dpath #(
  parameter int WORD_BITS   = mbrs_pkg::WORD_BITS_DEF,
  parameter int ALIGN_BYTES = mbrs_pkg::ALIGN_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mbrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbrs_pkg::ADDR_W-1:0]    cfg_data,
  input  logic [mbrs_pkg::IDX_W-1:0]     in_word_index,
  input  logic [mbrs_pkg::DATA_W-1:0]    in_word_bits,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mbrs_pkg::ADDR_W-1:0]    out_object_address,
  output logic                           out_last_of_word,
  input  mbrs_pkg::cmd_t                 cmd,
  output mbrs_pkg::sts_t                 sts
);

  localparam int AW       = mbrs_pkg::ADDR_W;
  localparam int BW       = $clog2(WORD_BITS);
  localparam int GRAN     = WORD_BITS * ALIGN_BYTES;

  // floor(x / d) = (x * m) >> (AW + k) for any AW-bit x, k = clog2(d)
  localparam int HALF = AW / 2;
  localparam int MW   = AW + 1;
  localparam int ACCW = AW + MW;
  localparam int KA   = $clog2(ALIGN_BYTES);
  localparam int KG   = $clog2(GRAN);
  localparam int RW   = KG + 1;
  localparam logic [MW-1:0] RCP_A =
    MW'(((64'd1 << (AW + KA)) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES));
  localparam logic [MW-1:0] RCP_G =
    MW'(((64'd1 << (AW + KG)) + 64'(GRAN) - 64'd1) / 64'(GRAN));

  // config registers
  logic [AW-1:0] heap_base_r, win_start_r, win_end_r;

  // divider lanes: 0 = window start, 1 = window end
  // first pass: word index = offset / bytes per word
  // second pass: bit index = leftover bytes / ALIGN_BYTES, left in acc
  logic [AW-1:0]   q_r     [2];
  logic [AW-1:0]   x_r     [2];
  logic [ACCW-1:0] acc_r   [2];
  logic [ACCW-1:0] acc_nxt [2];
  logic [AW-1:0]   q_now   [2];
  logic [RW-1:0]   rem_g   [2];
  logic [AW-1:0]   off     [2];
  logic [MW-1:0]   rcp;

  // item working set
  logic [WORD_BITS-1:0] word_r, word_nxt;
  logic [AW-1:0]        prod_r, base_r;
  logic [AW-1:0]        out_addr_r;
  logic                 out_last_r;
  logic                 out_valid_r;

  always_ff @(posedge clk) begin
    if (cfg_we) begin
      case (cfg_index)
        mbrs_pkg::CFG_HEAP_BASE:    heap_base_r <= cfg_data;
        mbrs_pkg::CFG_WINDOW_START: win_start_r <= cfg_data;
        mbrs_pkg::CFG_WINDOW_END:   win_end_r   <= cfg_data;
        default: ;
      endcase
    end
    if (!rst_n) begin
      heap_base_r <= '0;
      win_start_r <= '0;
      win_end_r   <= '0;
    end
  end

  assign off[0] = win_start_r - heap_base_r;
  assign off[1] = win_end_r - heap_base_r;
  assign rcp    = cmd.phase_bit ? RCP_A : RCP_G;

  // one 24 x 25 partial product per lane and cycle
  always_comb begin
    logic [HALF-1:0]    x_part;
    logic [MW-HALF-1:0] m_part;
    logic [MW-1:0]      pp;
    logic [ACCW-1:0]    pp_sh;
    for (int l = 0; l < 2; l++) begin
      x_part = cmd.mul_sel[1] ? x_r[l][AW-1:HALF] : x_r[l][HALF-1:0];
      m_part = cmd.mul_sel[0] ? rcp[MW-1:HALF] : {1'b0, rcp[HALF-1:0]};
      pp     = MW'(x_part) * MW'(m_part);
      case (cmd.mul_sel)
        2'd0:    pp_sh = ACCW'(pp);
        2'd3:    pp_sh = ACCW'(pp) << (2 * HALF);
        default: pp_sh = ACCW'(pp) << HALF;
      endcase
      acc_nxt[l] = acc_r[l] + pp_sh;
    end
  end

  // word index and the byte offset left inside that word
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      q_now[l] = AW'(acc_r[l] >> (AW + KG));
      rem_g[l] = x_r[l][RW-1:0] - q_now[l][RW-1:0] * RW'(GRAN);
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      if (cmd.load_div) begin
        x_r[l]   <= off[l];
        acc_r[l] <= '0;
      end else if (cmd.take_word) begin
        q_r[l]   <= q_now[l];
        x_r[l]   <= AW'(rem_g[l]);
        acc_r[l] <= '0;
      end else if (cmd.div_step) begin
        acc_r[l] <= acc_nxt[l];
      end
    end
  end

  // window trim at accept
  logic [AW-1:0]        idx_ext;
  logic [ACCW-1:0]      bit_s_full, bit_e_full;
  logic                 bit_ok;
  logic [BW-1:0]        b_s, b_e;
  logic                 keep;
  logic [WORD_BITS-1:0] lo_s, lo_e, mask;

  assign idx_ext    = {{(AW - mbrs_pkg::IDX_W){1'b0}}, in_word_index};
  assign bit_s_full = acc_r[0] >> (AW + KA);
  assign bit_e_full = acc_r[1] >> (AW + KA);
  assign bit_ok     = (bit_s_full < ACCW'(WORD_BITS)) && (bit_e_full < ACCW'(WORD_BITS));
  assign b_s        = BW'(bit_s_full);
  assign b_e        = BW'(bit_e_full);
  assign keep    = !(q_r[0] > q_r[1]) && (idx_ext >= q_r[0]) && (idx_ext <= q_r[1]);

  always_comb begin
    for (int k = 0; k < WORD_BITS; k++) begin
      lo_s[k] = (BW'(k) >= b_s);
      lo_e[k] = (BW'(k) < b_e);
    end
    mask = '0;
    if (keep) begin
      mask = (idx_ext == q_r[0]) ? lo_s : '1;
      if (idx_ext == q_r[1]) mask = mask & lo_e;
    end
  end

  // lowest marked bit of the remaining word
  logic [BW-1:0]        low_idx;
  logic [WORD_BITS-1:0] word_clr;
  logic [AW-1:0]        addr;

  always_comb begin
    low_idx = '0;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (word_r[k]) low_idx = BW'(k);
    end
  end

  assign word_clr = word_r & (word_r - WORD_BITS'(1));
  assign addr     = base_r + AW'(AW'(low_idx) * AW'(ALIGN_BYTES));

  always_comb begin
    word_nxt = word_r;
    if (cmd.accept) word_nxt = in_word_bits[WORD_BITS-1:0] & mask;
    else if (cmd.emit) word_nxt = word_clr;
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    if (cmd.accept) prod_r <= AW'(idx_ext * AW'(GRAN));
    if (cmd.base_load) base_r <= heap_base_r + prod_r;
    if (cmd.emit) begin
      out_addr_r <= addr;
      out_last_r <= (word_clr == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.word_zero = (word_r == '0);
  assign sts.last_bit  = (word_clr == '0);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid          = out_valid_r;
  assign out_object_address = out_addr_r;
  assign out_last_of_word   = out_last_r;

  `MBRS_ASSERT_NOW(a_emit_free, cmd.emit, !out_valid_r || out_ready, "emit while output held")
  `MBRS_ASSERT_NEXT(a_emit_valid, cmd.emit, out_valid_r, "emitted address not presented")
  `MBRS_ASSERT_NEXT(a_last_clears, cmd.emit && sts.last_bit, word_r == '0, "word left after last")
  `MBRS_ASSERT_NOW(a_bit_range, cmd.accept, bit_ok, "bit index out of range")

endmodule

@@ rtl/mark_bitmap_range_scan.sv @@
`timescale 1ns / 1ps

// mark bitmap range scan: each input item is one mark bitmap word and its word
// index; every set bit whose granule falls inside [window_start, window_end)
// comes out as one item carrying heap_base + (index*WORD_BITS + bit)*ALIGN_BYTES,
// lowest bit first, with last_of_word on the final one. a word with no surviving
// bit produces nothing. after reset and after every configuration write the block
// turns the window into start/end word and bit indexes with reciprocal
// multiplications built from four 24 x 25 bit partial products each (a load step,
// 4 steps dividing by WORD_BITS*ALIGN_BYTES, a remainder step, 4 steps dividing
// it by ALIGN_BYTES); in_ready stays low meanwhile. after that each item is
// accepted, its base address is formed, then one address is emitted per cycle
// while the output register is free, so stalls on the output hold the scan.
// results leave through an output register, so the next item is taken while
// the last address of the previous one waits.
module mark_bitmap_range_scan #(
  parameter int WORD_BITS   = mbrs_pkg::WORD_BITS_DEF,
  parameter int ALIGN_BYTES = mbrs_pkg::ALIGN_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mbrs_in_if.sink                        in_item,
  mbrs_out_if.source                     out_item,
  input  logic                           cfg_we,
  input  logic [mbrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbrs_pkg::ADDR_W-1:0]    cfg_data
);

  // control and status between sequencer and datapath
  mbrs_pkg::cmd_t cmd;
  mbrs_pkg::sts_t sts;
  logic           in_ready;

  mbrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .in_valid (in_item.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // window setup, trim, base address and scan
  mbrs_dpath #(
    .WORD_BITS   (WORD_BITS),
    .ALIGN_BYTES (ALIGN_BYTES)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_word_index      (in_item.word_index),
    .in_word_bits       (in_item.word_bits),
    .out_valid          (out_item.valid),
    .out_ready          (out_item.ready),
    .out_object_address (out_item.object_address),
    .out_last_of_word   (out_item.last_of_word),
    .cmd                (cmd),
    .sts                (sts)
  );

  // item taken only when the sequencer is waiting and no register write lands
  assign in_item.ready = in_ready;

endmodule

@@ verif/mbrs_scan_checker.sv @@
`timescale 1ns / 1ps

// watches both channels and the register port, works out the addresses each
// accepted word must produce and compares them in order
module mbrs_scan_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  mbrs_in_if                             in_ch,
  mbrs_out_if                            out_ch,
  input  logic                           cfg_we,
  input  logic [mbrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbrs_pkg::ADDR_W-1:0]    cfg_data,
  output int                             fail_count,
  output int                             addrs_waiting
);
  import mbrs_pkg::*;

  localparam int WORD_BITS   = WORD_BITS_DEF;
  localparam int ALIGN_BYTES = ALIGN_BYTES_DEF;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              last;
  } marked_obj_t;

  marked_obj_t       marked_q[$];
  logic [ADDR_W-1:0] heap_base;
  logic [ADDR_W-1:0] win_start;
  logic [ADDR_W-1:0] win_stop;
  int                fails = 0;

  // queue every granule address this word yields inside the window
  function automatic void expand_word(input logic [IDX_W-1:0] idx,
                                      input logic [DATA_W-1:0] bits);
    logic [ADDR_W-1:0] off_s;
    logic [ADDR_W-1:0] off_e;
    logic [63:0]       word_s;
    logic [63:0]       word_e;
    logic [63:0]       bit_s;
    logic [63:0]       bit_e;
    logic [63:0]       first_gran;
    logic [DATA_W-1:0] kept;
    marked_obj_t       hits[$];
    marked_obj_t       hit;
    off_s  = win_start - heap_base;
    off_e  = win_stop - heap_base;
    word_s = (64'(off_s) / ALIGN_BYTES) / WORD_BITS;
    word_e = (64'(off_e) / ALIGN_BYTES) / WORD_BITS;
    bit_s  = (64'(off_s) / ALIGN_BYTES) % WORD_BITS;
    bit_e  = (64'(off_e) / ALIGN_BYTES) % WORD_BITS;
    if (word_s > word_e || 64'(idx) < word_s || 64'(idx) > word_e) return;
    kept = bits;
    if (64'(idx) == word_s) kept &= ~((64'd1 << bit_s) - 64'd1);
    if (64'(idx) == word_e) kept &= (64'd1 << bit_e) - 64'd1;
    first_gran = 64'(idx) * WORD_BITS;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (kept[b]) begin
        hit.addr = ADDR_W'(64'(heap_base) + (first_gran + 64'(b)) * 64'(ALIGN_BYTES));
        hit.last = 1'b0;
        hits.push_back(hit);
      end
    end
    if (hits.size() > 0) hits[hits.size()-1].last = 1'b1;
    foreach (hits[i]) marked_q.push_back(hits[i]);
  endfunction

  always @(posedge clk) begin
    marked_obj_t want;
    if (!rst_n) begin
      heap_base = '0;
      win_start = '0;
      win_stop  = '0;
      marked_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HEAP_BASE:    heap_base = cfg_data;
          CFG_WINDOW_START: win_start = cfg_data;
          CFG_WINDOW_END:   win_stop  = cfg_data;
          default: ;
        endcase
      end
      // results of earlier words go first, so compare before queueing new ones
      if (out_ch.valid && out_ch.ready) begin
        if (marked_q.size() == 0) begin
          $error("object_address: unexpected item %h, last_of_word %b",
                 out_ch.object_address, out_ch.last_of_word);
          fails++;
        end else begin
          want = marked_q.pop_front();
          if (out_ch.object_address !== want.addr) begin
            $error("object_address: expected %h, got %h", want.addr,
                   out_ch.object_address);
            fails++;
          end
          if (out_ch.last_of_word !== want.last) begin
            $error("last_of_word: expected %b, got %b", want.last, out_ch.last_of_word);
            fails++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) expand_word(in_ch.word_index, in_ch.word_bits);
    end
    fail_count    <= fails;
    addrs_waiting <= marked_q.size();
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import mbrs_pkg::*;

  localparam int WORD_BITS    = WORD_BITS_DEF;
  localparam int ALIGN_BYTES  = ALIGN_BYTES_DEF;
  localparam int WORD_BYTES   = WORD_BITS * ALIGN_BYTES;
  // longest item (all bits kept) plus the output register, with margin
  localparam int SETTLE_CYCLES = WORD_BITS + 16;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int HOLD_CYCLES   = 600;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 25;
  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
  localparam logic [IDX_W-1:0]  IDX_MAX  = '1;

  // shapes of the random windows
  typedef enum int {
    WIN_NEAR,      // a few words close to the heap start
    WIN_FAR,       // a few words anywhere in the address space
    WIN_SINGLE,    // start and end inside one word
    WIN_REVERSED,  // end word below start word
    WIN_FULL,      // nearly the whole address space, wrapping
    WIN_TOP        // heap just under the top, addresses wrap
  } window_kind_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_data;
  logic                 hold_req;
  int                   fail_count;
  int                   addrs_waiting;
  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;
  int                   cycle_count = 0;

  // stimulus-side copy of the window, only used to aim word indexes
  logic [ADDR_W-1:0]    heap_r = '0;
  logic [63:0]          lo_word = '0;
  logic [63:0]          hi_word = '0;

  mbrs_in_if  in_ch ();
  mbrs_out_if out_ch ();

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  mark_bitmap_range_scan #(
    .WORD_BITS   (WORD_BITS),
    .ALIGN_BYTES (ALIGN_BYTES)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_ch),
    .out_item  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mbrs_scan_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .addrs_waiting (addrs_waiting)
  );

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL mark_bitmap_range_scan");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) hold_left = HOLD_CYCLES;
      else if (hold_left > 0) hold_left--;
      out_ch.ready <= (hold_left == 0) && !hold_req &&
                      ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // word index of a byte address under the current heap base
  function automatic logic [63:0] word_at(input logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] off;
    off = addr - heap_r;
    return 64'(off) / WORD_BYTES;
  endfunction

  task automatic set_idling(input idle_mode_t mode);
    send_idle_pct  = (mode == IDLE_SENDER)   ? 82 : (mode == IDLE_BOTH) ? 21 : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER) ? 82 : (mode == IDLE_BOTH) ? 21 : 0;
  endtask

  // all three registers back to back, we stays high across them
  task automatic write_window(input logic [ADDR_W-1:0] heap,
                              input logic [ADDR_W-1:0] start,
                              input logic [ADDR_W-1:0] stop);
    logic [63:0] ws;
    logic [63:0] we;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HEAP_BASE;
    cfg_data  <= heap;
    @(posedge clk);
    cfg_index <= CFG_WINDOW_START;
    cfg_data  <= start;
    @(posedge clk);
    cfg_index <= CFG_WINDOW_END;
    cfg_data  <= stop;
    @(posedge clk);
    cfg_we    <= 1'b0;
    heap_r  = heap;
    ws      = word_at(start);
    we      = word_at(stop);
    lo_word = (ws < we) ? ws : we;
    hi_word = (ws < we) ? we : ws;
  endtask

  // offer one word, with random gaps before it, and wait for the handshake
  task automatic send_word(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] bits);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.word_index <= idx;
    in_ch.word_bits  <= bits;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering, wait for every address, then let a zero-result word finish
  task automatic drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (addrs_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic pick_window(input window_kind_t kind);
    logic [ADDR_W-1:0] heap;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] stop;
    int                wsel;
    int                b_lo;
    int                b_hi;
    heap = ADDR_W'({$urandom, $urandom});
    case (kind)
      WIN_NEAR: begin
        start = heap + $urandom_range(0, 1 << 20);
        stop  = start + $urandom_range(0, 6 * WORD_BYTES);
      end
      WIN_FAR: begin
        start = heap + ADDR_W'({$urandom, $urandom});
        stop  = start + $urandom_range(0, 6 * WORD_BYTES);
      end
      WIN_SINGLE: begin
        wsel  = $urandom_range(0, 1000);
        b_lo  = $urandom_range(0, WORD_BITS - 1);
        b_hi  = $urandom_range(b_lo, WORD_BITS - 1);
        start = heap + wsel * WORD_BYTES + b_lo * ALIGN_BYTES +
                $urandom_range(0, ALIGN_BYTES - 1);
        stop  = heap + wsel * WORD_BYTES + b_hi * ALIGN_BYTES +
                $urandom_range(0, ALIGN_BYTES - 1);
      end
      WIN_REVERSED: begin
        start = heap + $urandom_range(4 * WORD_BYTES, 8 * WORD_BYTES);
        stop  = start - $urandom_range(WORD_BYTES, 4 * WORD_BYTES);
      end
      WIN_FULL: begin
        start = heap + $urandom_range(0, 4 * WORD_BYTES);
        stop  = heap - 1 - $urandom_range(0, 4 * WORD_BYTES);
      end
      default: begin
        heap  = ADDR_MAX - $urandom_range(0, 1 << 16);
        start = heap + $urandom_range(0, 2 * WORD_BYTES);
        stop  = start + $urandom_range(WORD_BYTES, 8 * WORD_BYTES);
      end
    endcase
    write_window(heap, start, stop);
  endtask

  // mostly indexes at or inside the window edges, some just outside or anywhere
  function automatic logic [IDX_W-1:0] pick_index();
    logic [63:0] span;
    logic [63:0] pick;
    int          r;
    span = hi_word - lo_word + 64'd1;
    r    = $urandom_range(0, 99);
    if (r < 30)      pick = lo_word;
    else if (r < 55) pick = hi_word;
    else if (r < 85) pick = lo_word + ({$urandom, $urandom} % span);
    else if (r < 92) pick = lo_word - 64'd1;
    else if (r < 97) pick = hi_word + 64'd1;
    else             pick = {$urandom, $urandom};
    return pick[IDX_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] pick_bits();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      2, 3, 4: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    window_kind_t kind;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_HEAP_BASE;
    cfg_data         <= '0;
    hold_req         <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.word_index <= '0;
    in_ch.word_bits  <= '0;
    set_idling(IDLE_NONE);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // registers still at reset: empty window, nothing comes out
    send_word('0, '1);
    send_word(IDX_MAX, '1);
    drain();

    // window over several words, unaligned at both ends
    write_window(48'h1000, 48'h1000 + 5 * WORD_BYTES + 3 * ALIGN_BYTES + 5,
                 48'h1000 + 9 * WORD_BYTES + 17 * ALIGN_BYTES + 3);
    send_word(5, '1);                       // trimmed below the start bit
    send_word(9, '1);                       // trimmed at the end bit
    send_word(7, '1);                       // full middle word
    send_word(7, '0);                       // nothing marked
    send_word(6, 64'h1);
    send_word(6, 64'h8000_0000_0000_0000);
    send_word(4, '1);                       // just before the window
    send_word(10, '1);                      // just past the window
    send_word(8, 64'hAAAA_AAAA_AAAA_AAAA);
    drain();

    // start and end in the same word
    write_window('0, 3 * WORD_BYTES + 10 * ALIGN_BYTES, 3 * WORD_BYTES + 50 * ALIGN_BYTES);
    send_word(3, '1);
    send_word(3, 64'h0006_0000_0000_0600);  // bits on both sides of each edge
    drain();

    // end word below start word
    write_window('0, 20 * WORD_BYTES, 10 * WORD_BYTES);
    send_word(15, '1);
    send_word(20, '1);
    drain();

    // window ending on a word boundary: end word yields nothing
    write_window(48'h0123_4567_8000, 48'h0123_4567_8000 + 2 * WORD_BYTES + ALIGN_BYTES,
                 48'h0123_4567_8000 + 4 * WORD_BYTES);
    send_word(4, '1);
    send_word(3, '1);
    drain();

    // whole address space with the heap near the top, addresses wrap
    write_window(ADDR_MAX - 4095, ADDR_MAX - 4095, ADDR_MAX - 4096);
    send_word('0, '1);
    send_word(63, '1);
    send_word(IDX_MAX, '1);
    drain();

    // registers at their maximum
    write_window(ADDR_MAX, ADDR_MAX, ADDR_MAX);
    send_word('0, '1);
    drain();
    write_window('0, ADDR_MAX, ADDR_MAX);
    send_word(IDX_MAX, '1);
    drain();

    // random windows, cycling through the idling modes
    for (int phase = 0; phase < PHASES; phase++) begin
      kind = (phase == 4) ? WIN_FULL : window_kind_t'($urandom_range(0, 5));
      pick_window(kind);
      set_idling(idle_mode_t'(phase % 4));
      // long receiver hold-off while words keep coming, so the input backs up
      if (phase == 4) begin
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // sender pause mid-phase until every address is out
        if (phase == 5 && i == PHASE_ITEMS / 2) drain();
        send_word(pick_index(), pick_bits());
      end
      drain();
    end

    if (fail_count == 0 && addrs_waiting == 0) begin
      $display("PASS mark_bitmap_range_scan");
    end else begin
      $display("FAIL mark_bitmap_range_scan");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/mbrs_pkg.sv
rtl/mbrs_in_if.sv
rtl/mbrs_out_if.sv
rtl/mbrs_ctrl.sv
rtl/mbrs_dpath.sv
rtl/mark_bitmap_range_scan.sv
verif/mbrs_scan_checker.sv
verif/tb_top.sv
